>>> sv/rtcp_nack_list_expander_macros.svh
// assertion macros for the rtcp nack list expander
`ifndef RTCP_NACK_LIST_EXPANDER_MACROS_SVH
`define RTCP_NACK_LIST_EXPANDER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, clocked on clk, off during reset
`define RNLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnle check failed");

// next-cycle implication, clocked on clk, off during reset
`define RNLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnle check failed");

`else

`define RNLE_ASSERT_NOW(lbl, ante, cons)
`define RNLE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/rnle_pkg.sv
// shared types, codes and helpers for the nack list expander
package rnle_pkg;

  localparam int BLP_BITS = 16;
  localparam int IDX_W    = $clog2(BLP_BITS);
  localparam int SEQ_W    = 16;
  localparam int SSRC_W   = 32;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 2;

  localparam logic [POS_W-1:0] POS_SENDER = 2'd0;
  localparam logic [POS_W-1:0] POS_MEDIA  = 2'd1;
  localparam logic [POS_W-1:0] POS_FCI    = 2'd2;

  localparam logic KIND_SEQ     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PID,
    ST_BLP,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_pid;
    logic emit_blp;
    logic emit_sum;
    logic run_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic pos_fci;
    logic last_word;
    logic mask_any;
    logic mask_single;
  } sts_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [SSRC_W-1:0] sender_ssrc;
    logic [SSRC_W-1:0] media_ssrc;
    logic [SEQ_W-1:0]  total_count;
    logic              status;
    logic              run_end;
  } res_t;

  // index of the lowest set bit, zero when no bit is set
  function automatic logic [IDX_W-1:0] lowest_set(input logic [BLP_BITS-1:0] mask);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = BLP_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> sv/rnle_in_if.sv
// input request channel: payload word and last flag
interface rnle_in_if;
  logic                           valid;
  logic                           ready;
  logic [rnle_pkg::WORD_W-1:0]    payload_word;
  logic                           last_word;

  modport source (output valid, output payload_word, output last_word, input ready);
  modport sink   (input valid, input payload_word, input last_word, output ready);
endinterface

>>> sv/rnle_out_if.sv
// result request channel: one sequence number or summary per request
interface rnle_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [rnle_pkg::SEQ_W-1:0]     seq_number;
  logic [rnle_pkg::SSRC_W-1:0]    sender_ssrc;
  logic [rnle_pkg::SSRC_W-1:0]    media_ssrc;
  logic [rnle_pkg::SEQ_W-1:0]     total_count;
  logic                           status;
  logic                           run_end;

  modport source (output valid, output kind, output seq_number, output sender_ssrc,
                  output media_ssrc, output total_count, output status,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input seq_number, input sender_ssrc,
                  input media_ssrc, input total_count, input status,
                  input run_end, output ready);
endinterface

>>> sv/rtcp_nack_list_expander.sv
// ssrc word not marked last: no result; ssrc word marked last: a summary result
// fci word: its pid, one number per set mask bit, then a summary when marked last
// results pass through the result register; input is ready only while idle
// rate: the scan feeds the result register one sequence number a cycle while it is free
// reset: synchronous active low; clears word position, count, ssrcs and result valid
// top level of the rtcp generic nack list expander
module rtcp_nack_list_expander (
  input  logic       clk,
  input  logic       rst_n,
  rnle_in_if.sink    in_chan,
  rnle_out_if.source out_chan
);

  rnle_pkg::cmd_t cmd;
  rnle_pkg::sts_t sts;
  rnle_pkg::res_t res;
  logic           out_valid;

  // controller: one word at a time; ready only while idle
  rnle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_word),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: holds packet state, scans the lost-packet mask from low bit up,
  // and owns the result register toward the sink
  rnle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_chan.payload_word),
    .in_last   (in_chan.last_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  // unpack the registered result onto the output channel
  assign out_chan.valid       = out_valid;
  assign out_chan.kind        = res.kind;
  assign out_chan.seq_number  = res.seq_number;
  assign out_chan.sender_ssrc = res.sender_ssrc;
  assign out_chan.media_ssrc  = res.media_ssrc;
  assign out_chan.total_count = res.total_count;
  assign out_chan.status      = res.status;
  assign out_chan.run_end     = res.run_end;

endmodule

>>> sv/rnle_ctrl.sv
// controller state machine: sequences pid, mask bits and summary
`include "rtcp_nack_list_expander_macros.svh"

module rnle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  rnle_pkg::sts_t sts,
  output rnle_pkg::cmd_t cmd
);

  rnle_pkg::state_t state_r;
  rnle_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rnle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      rnle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.pos_fci) begin
            state_nxt = rnle_pkg::ST_PID;
          end else if (in_last) begin
            state_nxt = rnle_pkg::ST_SUM;
          end
        end
      end
      rnle_pkg::ST_PID: begin
        if (sts.out_free) begin
          cmd.emit_pid = 1'b1;
          cmd.run_end  = !sts.mask_any && !sts.last_word;
          if (sts.mask_any) begin
            state_nxt = rnle_pkg::ST_BLP;
          end else if (sts.last_word) begin
            state_nxt = rnle_pkg::ST_SUM;
          end else begin
            state_nxt = rnle_pkg::ST_IDLE;
          end
        end
      end
      rnle_pkg::ST_BLP: begin
        if (sts.out_free) begin
          cmd.emit_blp = 1'b1;
          cmd.run_end  = sts.mask_single && !sts.last_word;
          if (sts.mask_single) begin
            state_nxt = sts.last_word ? rnle_pkg::ST_SUM : rnle_pkg::ST_IDLE;
          end
        end
      end
      rnle_pkg::ST_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          cmd.run_end  = 1'b1;
          state_nxt    = rnle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rnle_pkg::ST_IDLE;
      end
    endcase
  end

  `RNLE_ASSERT_NEXT(a_fci_to_pid, cmd.load && sts.pos_fci, state_r == rnle_pkg::ST_PID)
  `RNLE_ASSERT_NOW(a_blp_has_bits, state_r == rnle_pkg::ST_BLP, sts.mask_any)
  `RNLE_ASSERT_NEXT(a_sum_to_idle, cmd.emit_sum, state_r == rnle_pkg::ST_IDLE)

endmodule

>>> sv/rnle_dp.sv
// datapath: held ssrcs, word position, count, mask scan and result register
`include "rtcp_nack_list_expander_macros.svh"

module rnle_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rnle_pkg::WORD_W-1:0] in_word,
  input  logic                        in_last,
  input  rnle_pkg::cmd_t              cmd,
  output rnle_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rnle_pkg::res_t              out_res
);

  logic [rnle_pkg::POS_W-1:0]    pos_r,    pos_nxt;
  logic [rnle_pkg::SEQ_W-1:0]    count_r,  count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rnle_pkg::SSRC_W-1:0]   sender_r, sender_nxt;
  logic [rnle_pkg::SSRC_W-1:0]   media_r,  media_nxt;
  logic [rnle_pkg::SEQ_W-1:0]    pid_r,    pid_nxt;
  logic [rnle_pkg::BLP_BITS-1:0] mask_r,   mask_nxt;
  logic                          last_r,   last_nxt;
  logic                          short_r,  short_nxt;
  rnle_pkg::res_t                res_r,    res_nxt;

  logic [rnle_pkg::IDX_W-1:0]    low_idx;
  logic [rnle_pkg::BLP_BITS-1:0] mask_rest;
  logic [rnle_pkg::SEQ_W-1:0]    count_inc;

  assign low_idx   = rnle_pkg::lowest_set(mask_r);
  assign mask_rest = mask_r & (mask_r - rnle_pkg::BLP_BITS'(1));
  assign count_inc = count_r + rnle_pkg::SEQ_W'(1);

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.pos_fci     = pos_r[1];
  assign sts.last_word   = last_r;
  assign sts.mask_any    = |mask_r;
  assign sts.mask_single = (|mask_r) && !(|mask_rest);

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    sender_nxt    = sender_r;
    media_nxt     = media_r;
    pid_nxt       = pid_r;
    mask_nxt      = mask_r;
    last_nxt      = last_r;
    short_nxt     = short_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      pid_nxt   = in_word[rnle_pkg::WORD_W-1:rnle_pkg::BLP_BITS];
      mask_nxt  = in_word[rnle_pkg::BLP_BITS-1:0];
      last_nxt  = in_last;
      short_nxt = (pos_r == rnle_pkg::POS_SENDER);
      case (pos_r)
        rnle_pkg::POS_SENDER: begin
          sender_nxt = in_word;
          pos_nxt    = rnle_pkg::POS_MEDIA;
        end
        rnle_pkg::POS_MEDIA: begin
          media_nxt = in_word;
          pos_nxt   = rnle_pkg::POS_FCI;
        end
        default: begin
          // a stray position 3 behaves as an fci word
          pos_nxt = rnle_pkg::POS_FCI;
        end
      endcase
    end

    if (cmd.emit_pid) begin
      count_nxt           = count_inc;
      res_nxt.kind        = rnle_pkg::KIND_SEQ;
      res_nxt.seq_number  = pid_r;
      res_nxt.sender_ssrc = sender_r;
      res_nxt.media_ssrc  = media_r;
      res_nxt.total_count = count_inc;
      res_nxt.status      = rnle_pkg::STATUS_OK;
      res_nxt.run_end     = cmd.run_end;
      out_valid_nxt       = 1'b1;
    end

    if (cmd.emit_blp) begin
      count_nxt           = count_inc;
      mask_nxt            = mask_rest;
      res_nxt.kind        = rnle_pkg::KIND_SEQ;
      res_nxt.seq_number  = pid_r + rnle_pkg::SEQ_W'(low_idx) + rnle_pkg::SEQ_W'(1);
      res_nxt.sender_ssrc = sender_r;
      res_nxt.media_ssrc  = media_r;
      res_nxt.total_count = count_inc;
      res_nxt.status      = rnle_pkg::STATUS_OK;
      res_nxt.run_end     = cmd.run_end;
      out_valid_nxt       = 1'b1;
    end

    if (cmd.emit_sum) begin
      res_nxt.kind       = rnle_pkg::KIND_SUMMARY;
      res_nxt.seq_number = '0;
      res_nxt.run_end    = cmd.run_end;
      if (short_r) begin
        res_nxt.sender_ssrc = '0;
        res_nxt.media_ssrc  = '0;
        res_nxt.total_count = '0;
        res_nxt.status      = rnle_pkg::STATUS_SHORT;
      end else begin
        res_nxt.sender_ssrc = sender_r;
        res_nxt.media_ssrc  = media_r;
        res_nxt.total_count = count_r;
        res_nxt.status      = rnle_pkg::STATUS_OK;
      end
      pos_nxt       = rnle_pkg::POS_SENDER;
      count_nxt     = '0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= rnle_pkg::POS_SENDER;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sender_r    <= '0;
      media_r     <= '0;
    end else begin
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      sender_r    <= sender_nxt;
      media_r     <= media_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r   <= pid_nxt;
    mask_r  <= mask_nxt;
    last_r  <= last_nxt;
    short_r <= short_nxt;
    res_r   <= res_nxt;
  end

  `RNLE_ASSERT_NEXT(a_sum_clears, cmd.emit_sum, pos_r == rnle_pkg::POS_SENDER && count_r == '0)
  `RNLE_ASSERT_NOW(a_sum_fields, out_valid_r && res_r.kind == rnle_pkg::KIND_SUMMARY, res_r.seq_number == '0 && res_r.run_end)
  `RNLE_ASSERT_NOW(a_short_only_sum, out_valid_r && res_r.status == rnle_pkg::STATUS_SHORT, res_r.kind == rnle_pkg::KIND_SUMMARY && res_r.total_count == '0)

endmodule

>>> dv/testbench.sv
// self-checking testbench for the rtcp generic nack list expander
module testbench;
  import rnle_pkg::*;

  // generous cycle ceiling, several times the slowest legal run with every stall at its longest
  localparam int unsigned CYCLE_LIMIT = 300_000;
  // words left in the queue when the random idling stops
  localparam int QUIET_TAIL = 40;
  // cycles allowed after the last expected result for anything stray to show up
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } nack_word_t;

  logic clk;
  logic rst_n;

  rnle_in_if  in_if ();
  rnle_out_if out_if ();

  rtcp_nack_list_expander i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // words waiting to be sent and sequence numbers or summaries still owed by the block
  nack_word_t nack_words[$];
  res_t       expected_nacks[$];

  // shadow of the block state
  logic [POS_W-1:0]  word_pos;
  logic [SSRC_W-1:0] held_sender;
  logic [SSRC_W-1:0] held_media;
  logic [SEQ_W-1:0]  lost_count;

  logic        in_fire;
  int          in_gap;
  int          out_gap;
  int unsigned cycles;
  int          mismatches;
  int          words_sent;
  int          seq_seen;
  int          summaries_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // tail of the run: no more random idling
  function automatic logic quiet();
    return nack_words.size() < QUIET_TAIL;
  endfunction

  function automatic void push_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                      input logic [SSRC_W-1:0] snd,
                                      input logic [SSRC_W-1:0] med,
                                      input logic [SEQ_W-1:0] cnt, input logic st);
    res_t r;
    r.kind        = kind;
    r.seq_number  = seq;
    r.sender_ssrc = snd;
    r.media_ssrc  = med;
    r.total_count = cnt;
    r.status      = st;
    r.run_end     = 1'b0;
    expected_nacks.push_back(r);
  endfunction

  // expand one accepted payload word into the results it owes
  function automatic void expand_nack_word(input logic [WORD_W-1:0] word, input logic last);
    logic [SEQ_W-1:0] pid;
    logic [15:0]      blp;
    logic             first_word;
    int               owed_before;
    owed_before = expected_nacks.size();
    first_word  = 1'b0;
    if (word_pos == POS_SENDER) begin
      held_sender = word;
      word_pos    = POS_MEDIA;
      first_word  = 1'b1;
    end else if (word_pos == POS_MEDIA) begin
      held_media = word;
      word_pos   = POS_FCI;
    end else begin
      // fci entry: the pid itself, then one number per set mask bit, low bit first
      pid = word[31:16];
      blp = word[15:0];
      lost_count++;
      push_result(KIND_SEQ, pid, held_sender, held_media, lost_count, STATUS_OK);
      for (int j = 0; j < BLP_BITS; j++) begin
        if (blp[j]) begin
          lost_count++;
          push_result(KIND_SEQ, pid + SEQ_W'(j + 1), held_sender, held_media, lost_count,
                      STATUS_OK);
        end
      end
      word_pos = POS_FCI;
    end
    if (last) begin
      // a one-word payload reports short with all other fields cleared
      if (first_word) begin
        push_result(KIND_SUMMARY, '0, '0, '0, '0, STATUS_SHORT);
      end else begin
        push_result(KIND_SUMMARY, '0, held_sender, held_media, lost_count, STATUS_OK);
      end
      word_pos   = POS_SENDER;
      lost_count = '0;
    end
    if (expected_nacks.size() > owed_before) begin
      expected_nacks[expected_nacks.size() - 1].run_end = 1'b1;
    end
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
      end
    end
  endfunction

  function automatic void add_word(input logic [WORD_W-1:0] word, input logic last);
    nack_word_t w;
    w.word = word;
    w.last = last;
    nack_words.push_back(w);
  endfunction

  // stimulus: directed packets, then random packets
  initial begin
    int          n_fci;
    int          shape;
    int          random_words;
    logic [15:0] mask;
    logic [15:0] pid;

    // one-word payload, reported as too short
    add_word(32'hFFFF_FFFF, 1'b1);
    // exactly two words: count zero, both ssrcs
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    // fci extremes: full mask from pid 0xffff wraps the sequence numbers
    add_word(32'h1234_5678, 1'b0);
    add_word(32'h9ABC_DEF0, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'h8000_0001, 1'b0);
    add_word(32'h0001_8000, 1'b0);
    add_word(32'hFFFE_0001, 1'b1);
    // short payload while old ssrcs are still held
    add_word(32'hAAAA_AAAA, 1'b1);
    add_word(32'h5555_5555, 1'b0);
    add_word(32'h0000_0001, 1'b0);
    add_word(32'hFFF0_5555, 1'b1);
    // last word is an fci word with an empty mask
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b1);

    // random packets: mostly well formed with random content, some short or bare ones
    random_words = 0;
    while (random_words < 200) begin
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        add_word($urandom, 1'b1);
        random_words += 1;
      end else if (shape == 1) begin
        add_word($urandom, 1'b0);
        add_word($urandom, 1'b1);
        random_words += 2;
      end else begin
        n_fci = $urandom_range(1, 5);
        add_word($urandom, 1'b0);
        add_word($urandom, 1'b0);
        for (int i = 0; i < n_fci; i++) begin
          case ($urandom_range(0, 5))
            0:       mask = '0;
            1:       mask = '1;
            2:       mask = 16'(1) << $urandom_range(0, 15);
            default: mask = 16'($urandom);
          endcase
          // pids near the top of the range exercise sequence number wrap
          pid = ($urandom_range(0, 3) == 0) ? 16'hFFF0 | 16'($urandom_range(0, 15))
                                            : 16'($urandom);
          add_word({pid, mask}, i == n_fci - 1);
        end
        random_words += n_fci + 2;
      end
    end
  end

  // reset, then wait for the queues to drain and report
  initial begin
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (nack_words.size() != 0 || expected_nacks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_nacks.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_nacks.size());
    end
    $display("covered %0d payload words: %0d lost sequence numbers and %0d packet summaries,",
             words_sent, seq_seen, summaries_seen);
    $display("short and two-word payloads, full and empty masks, pid wrap, stalls both sides");
    if (mismatches == 0) begin
      $display("rtcp_nack_list_expander regression: pass");
    end else begin
      $display("rtcp_nack_list_expander regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("rtcp_nack_list_expander regression: fail");
      $finish;
    end
  end

  // input driver: changes on the falling edge, holds a request until it is taken
  always @(negedge clk) begin
    logic next_valid;
    next_valid = 1'b0;
    if (rst_n) begin
      if (in_fire) begin
        nack_words.delete(0);
      end
      if (in_gap > 0) begin
        in_gap--;
      end else if (in_if.valid && !in_fire) begin
        next_valid = 1'b1;
      end else if (!quiet() && $urandom_range(0, 5) == 0) begin
        // start an idle burst, this one included
        in_gap = $urandom_range(0, 10);
      end else begin
        next_valid = nack_words.size() != 0;
      end
    end
    in_if.valid <= next_valid;
    if (next_valid) begin
      in_if.payload_word <= nack_words[0].word;
      in_if.last_word    <= nack_words[0].last;
    end
  end

  // result sink: ready stalls in bursts, steady once the tail of the run is reached
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
      end else if (!quiet() && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 10);
      end else begin
        next_ready = 1'b1;
      end
    end
    out_if.ready <= next_ready;
  end

  // monitor: predicts on each accepted word and checks each accepted result
  always @(posedge clk) begin
    res_t want;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      words_sent++;
      expand_nack_word(in_if.payload_word, in_if.last_word);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (out_if.kind == KIND_SUMMARY) begin
        summaries_seen++;
      end else begin
        seq_seen++;
      end
      if (expected_nacks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, got kind %0d seq %0h count %0h",
                   $time, out_if.kind, out_if.seq_number, out_if.total_count);
        end
      end else begin
        want = expected_nacks.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_if.kind));
        check_field("seq_number", 32'(want.seq_number), 32'(out_if.seq_number));
        check_field("sender_ssrc", want.sender_ssrc, out_if.sender_ssrc);
        check_field("media_ssrc", want.media_ssrc, out_if.media_ssrc);
        check_field("total_count", 32'(want.total_count), 32'(out_if.total_count));
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("run_end", 32'(want.run_end), 32'(out_if.run_end));
      end
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.payload_word = '0;
    in_if.last_word    = 1'b0;
    out_if.ready       = 1'b0;
    in_fire            = 1'b0;
    in_gap             = 0;
    out_gap            = 0;
    cycles             = 0;
    mismatches         = 0;
    words_sent         = 0;
    seq_seen           = 0;
    summaries_seen     = 0;
    word_pos           = POS_SENDER;
    held_sender        = '0;
    held_media         = '0;
    lost_count         = '0;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rnle_pkg.sv
sv/rnle_in_if.sv
sv/rnle_out_if.sv
sv/rnle_ctrl.sv
sv/rnle_dp.sv
sv/rtcp_nack_list_expander.sv
dv/testbench.sv
